### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the heap queue RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define BHPQ_ASSERT(lbl, clk, rst_n, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define BHPQ_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

### src/bhpq_pkg.sv
// ----------------------------------------------------------------------------
// Heap queue package
// Sizes, operation codes and status codes of the binary heap priority queue.
// ----------------------------------------------------------------------------
package bhpq_pkg;

	localparam int CAPACITY = 1024;
	localparam int ADDR_W   = $clog2(CAPACITY);
	localparam int CNT_W    = $clog2(CAPACITY + 1);
	localparam int DATA_W   = 32;
	localparam int M_DATA_W = ((DATA_W + CNT_W + 7) / 8) * 8;
	localparam int M_USER_W = 1 + 2;

	// Operation requested by an input beat
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	// Ordering selected by the configuration bit
	localparam logic ORDER_MAX = 1'b0;
	localparam logic ORDER_MIN = 1'b1;

	// Result status
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

endpackage

### src/bhpq_ram.sv
// ----------------------------------------------------------------------------
// Heap store RAM
// Simple dual-port memory: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module bhpq_ram #(
	parameter int DEPTH  = 1024,
	parameter int DATA_W = 32,
	parameter int ADDR_W = $clog2(DEPTH)
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [DATA_W-1:0] wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [DATA_W-1:0] rdata
);

	logic [DATA_W-1:0] mem [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port
	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule

### src/bhpq_cmp.sv
// ----------------------------------------------------------------------------
// Heap order comparator
// Tells whether operand a belongs strictly above operand b in the heap.
// ----------------------------------------------------------------------------
module bhpq_cmp
	import bhpq_pkg::*;
(
	input  logic              order_mode,
	input  logic [DATA_W-1:0] a,
	input  logic [DATA_W-1:0] b,
	output logic              better
);

	logic a_gt_b;
	logic b_gt_a;

	// Signed compare both ways
	assign a_gt_b = $signed(a) > $signed(b);
	assign b_gt_a = $signed(b) > $signed(a);

	// Larger wins in a max-heap, smaller wins in a min-heap
	assign better = (order_mode == ORDER_MIN) ? b_gt_a : a_gt_b;

endmodule

### src/binary_heap_priority_queue.sv
// Sequencing: a dropped push, an ignored pop or a pop that empties the heap goes
// straight to the result; a push climbs one level per parent read and compare;
// a pop loads the last element, then per level reads left, reads right, picks a
// child and compares. Throughput: one item at a time, the next beat is taken once
// the result is registered; the RAM read port and shared comparator set the cost.
// Reset clears count, order mode and handshake state; the store is not cleared.
// ----------------------------------------------------------------------------
// Binary heap priority queue
// Array heap of signed 32-bit values in a RAM, sifted one level at a time.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module binary_heap_priority_queue
	import bhpq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	// Configuration
	input  logic                cfg_we,
	input  logic [0:0]          cfg_wdata,   // [0] order_mode
	// Input stream
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [31:0]         s_tdata,     // [31:0] value
	input  logic [0:0]          s_tuser,     // [0] func
	// Result stream
	output logic                m_tvalid,
	input  logic                m_tready,
	output logic [M_DATA_W-1:0] m_tdata,     // [31:0] top_value, [42:32] count, [47:43] zero
	output logic [M_USER_W-1:0] m_tuser      // [0] is_empty, [2:1] status
);

	localparam int IDX_W = ADDR_W + 2;

	typedef enum logic [3:0] {
		S_IDLE,
		S_UP_CHK,
		S_UP_CMP,
		S_POP_LD,
		S_POP_CAP,
		S_DN_L,
		S_DN_R,
		S_DN_SEL,
		S_DN_CMP,
		S_DONE
	} state_t;

	state_t            state_q;
	logic              order_q;
	logic [CNT_W-1:0]  cnt_q;
	logic [ADDR_W-1:0] pos_q;
	logic [ADDR_W-1:0] cidx_q;
	logic              has_r_q;
	logic [DATA_W-1:0] cur_q;
	logic [DATA_W-1:0] child_q;
	logic [DATA_W-1:0] top_q;
	status_t           status_q;

	logic              out_valid_q;
	logic [DATA_W-1:0] out_top_q;
	logic              out_empty_q;
	logic [CNT_W-1:0]  out_cnt_q;
	status_t           out_status_q;

	logic              in_acc;
	logic              we;
	logic [ADDR_W-1:0] waddr;
	logic [DATA_W-1:0] wdata;
	logic [ADDR_W-1:0] raddr;
	logic [DATA_W-1:0] rdata;
	logic [DATA_W-1:0] cmp_a;
	logic [DATA_W-1:0] cmp_b;
	logic              cmp_better;
	logic [ADDR_W-1:0] parent;
	logic [IDX_W-1:0]  lc_w;
	logic [IDX_W-1:0]  rc_w;
	logic [IDX_W-1:0]  cnt_w;

	// Handshake
	assign s_tready = (state_q == S_IDLE);
	assign in_acc   = s_tvalid && s_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(M_DATA_W - DATA_W - CNT_W){1'b0}}, out_cnt_q, out_top_q};
	assign m_tuser  = {out_status_q, out_empty_q};

	// Index arithmetic
	assign parent = (pos_q - ADDR_W'(1)) >> 1;
	assign lc_w   = IDX_W'({pos_q, 1'b1});
	assign rc_w   = lc_w + IDX_W'(1);
	assign cnt_w  = IDX_W'(cnt_q);

	// Shared comparator operand select
	always_comb begin
		cmp_a = child_q;
		cmp_b = cur_q;
		case (state_q)
			S_UP_CMP: begin
				cmp_a = cur_q;
				cmp_b = rdata;
			end
			S_DN_SEL: begin
				cmp_a = rdata;
				cmp_b = child_q;
			end
			default: begin
				cmp_a = child_q;
				cmp_b = cur_q;
			end
		endcase
	end

	bhpq_cmp u_cmp (
		.order_mode (order_q),
		.a          (cmp_a),
		.b          (cmp_b),
		.better     (cmp_better)
	);

	// Read address per sequencer step
	always_comb begin
		case (state_q)
			S_UP_CHK: raddr = parent;
			S_POP_LD: raddr = cnt_q[ADDR_W-1:0];
			S_DN_L:   raddr = lc_w[ADDR_W-1:0];
			S_DN_R:   raddr = rc_w[ADDR_W-1:0];
			default:  raddr = pos_q;
		endcase
	end

	// Write port: place the moving element or shift the hole
	always_comb begin
		we    = 1'b0;
		waddr = pos_q;
		wdata = cur_q;
		case (state_q)
			S_UP_CHK: begin
				we = (pos_q == '0);
			end
			S_UP_CMP: begin
				we    = 1'b1;
				wdata = cmp_better ? rdata : cur_q;
			end
			S_DN_L: begin
				we = (lc_w >= cnt_w);
			end
			S_DN_CMP: begin
				we    = 1'b1;
				wdata = cmp_better ? child_q : cur_q;
			end
			default: begin
				we = 1'b0;
			end
		endcase
	end

	bhpq_ram #(
		.DEPTH  (CAPACITY),
		.DATA_W (DATA_W),
		.ADDR_W (ADDR_W)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.raddr (raddr),
		.rdata (rdata)
	);

	// Mirror the root so the result needs no extra read
	always_ff @(posedge clk) begin
		if (we && (waddr == '0)) begin
			top_q <= wdata;
		end
	end

	// Sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			order_q     <= ORDER_MAX;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				order_q <= cfg_wdata[0];
			end
			// Drop the taken result; the done step reloads it on its own edge
			if (out_valid_q && m_tready && (state_q != S_DONE)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (in_acc) begin
						cur_q <= s_tdata;
						if (s_tuser[0] == FUNC_PUSH) begin
							if (cnt_q >= CNT_W'(CAPACITY)) begin
								status_q <= ST_FULL;
								state_q  <= S_DONE;
							end else begin
								status_q <= ST_OK;
								pos_q    <= cnt_q[ADDR_W-1:0];
								cnt_q    <= cnt_q + CNT_W'(1);
								state_q  <= S_UP_CHK;
							end
						end else begin
							if (cnt_q == '0) begin
								status_q <= ST_EMPTY;
								state_q  <= S_DONE;
							end else begin
								status_q <= ST_OK;
								cnt_q    <= cnt_q - CNT_W'(1);
								pos_q    <= '0;
								state_q  <= (cnt_q == CNT_W'(1)) ? S_DONE : S_POP_LD;
							end
						end
					end
				end
				// Climb: the parent is read while the hole waits
				S_UP_CHK: begin
					state_q <= (pos_q == '0) ? S_DONE : S_UP_CMP;
				end
				S_UP_CMP: begin
					if (cmp_better) begin
						pos_q   <= parent;
						state_q <= S_UP_CHK;
					end else begin
						state_q <= S_DONE;
					end
				end
				// Pop: fetch the last element as the one to sink
				S_POP_LD: begin
					state_q <= S_POP_CAP;
				end
				S_POP_CAP: begin
					cur_q   <= rdata;
					state_q <= S_DN_L;
				end
				// Descend: read left, then right, pick child, compare
				S_DN_L: begin
					state_q <= (lc_w >= cnt_w) ? S_DONE : S_DN_R;
				end
				S_DN_R: begin
					child_q <= rdata;
					cidx_q  <= lc_w[ADDR_W-1:0];
					has_r_q <= (rc_w < cnt_w);
					state_q <= S_DN_SEL;
				end
				S_DN_SEL: begin
					if (has_r_q && cmp_better) begin
						child_q <= rdata;
						cidx_q  <= cidx_q + ADDR_W'(1);
					end
					state_q <= S_DN_CMP;
				end
				S_DN_CMP: begin
					if (cmp_better) begin
						pos_q   <= cidx_q;
						state_q <= S_DN_L;
					end else begin
						state_q <= S_DONE;
					end
				end
				// Hand off the result once the output register is free
				S_DONE: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q  <= 1'b1;
						out_top_q    <= (cnt_q == '0) ? '1 : top_q;
						out_empty_q  <= (cnt_q == '0);
						out_cnt_q    <= cnt_q;
						out_status_q <= status_q;
						state_q      <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`BHPQ_ASSERT(a_cnt_bound, clk, arst_n, cnt_q <= CNT_W'(CAPACITY), "count above capacity")
	`BHPQ_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_acc, state_q != S_IDLE, "accepted item left no work")
	`BHPQ_ASSERT(a_no_idle_write, clk, arst_n, !(we && (state_q == S_IDLE || state_q == S_DONE)), "store written outside a sift")
	`BHPQ_ASSERT(a_empty_flag, clk, arst_n, !m_tvalid || (m_tuser[0] == (m_tdata[DATA_W+CNT_W-1:DATA_W] == '0)), "empty flag disagrees with count")
	`BHPQ_ASSERT(a_full_status, clk, arst_n, !(m_tvalid && m_tuser[M_USER_W-1:1] == ST_FULL) || (m_tdata[DATA_W+CNT_W-1:DATA_W] == CNT_W'(CAPACITY)), "full status with room left")

endmodule

### dv/heap_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Heap queue checker
// Watches the configuration port and both stream channels, keeps its own copy
// of the heap, predicts the result of every accepted input beat and compares
// each result beat against the oldest prediction, field by field.
// ----------------------------------------------------------------------------
module heap_checker
	import bhpq_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [0:0]          cfg_wdata,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [31:0]         s_tdata,
	input  logic [0:0]          s_tuser,
	input  logic                m_tvalid,
	input  logic                m_tready,
	input  logic [M_DATA_W-1:0] m_tdata,
	input  logic [M_USER_W-1:0] m_tuser,
	output int                  mismatch_count,
	output int                  pending,
	output int                  stored
);

	typedef struct {
		logic [DATA_W-1:0] top_value;
		logic              is_empty;
		logic [CNT_W-1:0]  count;
		status_t           status;
	} heap_result_t;

	logic [DATA_W-1:0] heap_mem [CAPACITY];
	int                heap_len;
	logic              order_sel;
	heap_result_t      expected_q [$];

	// True when a belongs strictly above b under the selected order
	function automatic bit outranks(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
		if (order_sel == ORDER_MIN)
			return $signed(a) < $signed(b);
		return $signed(a) > $signed(b);
	endfunction

	task automatic swap_entries(int i, int j);
		logic [DATA_W-1:0] t;
		t           = heap_mem[i];
		heap_mem[i] = heap_mem[j];
		heap_mem[j] = t;
	endtask

	// Append at the tail and climb while strictly better than the parent
	task automatic heap_insert(logic [DATA_W-1:0] v);
		int pos;
		int parent;
		heap_mem[heap_len] = v;
		pos = heap_len;
		heap_len++;
		while (pos > 0) begin
			parent = (pos - 1) / 2;
			if (!outranks(heap_mem[pos], heap_mem[parent]))
				break;
			swap_entries(pos, parent);
			pos = parent;
		end
	endtask

	// Move the tail to the root and descend along the preferred child;
	// a tie between children goes left
	task automatic heap_remove_top();
		int pos;
		int child;
		heap_len--;
		heap_mem[0] = heap_mem[heap_len];
		pos = 0;
		while (1) begin
			child = 2 * pos + 1;
			if (child >= heap_len)
				break;
			if (child + 1 < heap_len && outranks(heap_mem[child + 1], heap_mem[child]))
				child++;
			if (!outranks(heap_mem[child], heap_mem[pos]))
				break;
			swap_entries(pos, child);
			pos = child;
		end
	endtask

	task automatic predict_beat(input logic fn, input logic [DATA_W-1:0] v,
			output heap_result_t r);
		r.status = ST_OK;
		if (fn == FUNC_PUSH) begin
			if (heap_len >= CAPACITY)
				r.status = ST_FULL;
			else
				heap_insert(v);
		end else begin
			if (heap_len == 0)
				r.status = ST_EMPTY;
			else
				heap_remove_top();
		end
		r.top_value = (heap_len != 0) ? heap_mem[0] : '1;
		r.is_empty  = (heap_len == 0);
		r.count     = heap_len[CNT_W-1:0];
	endtask

	task automatic check_field(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s: expected %0d, got %0d", name, exp_v, act_v);
			mismatch_count++;
		end
	endtask

	// Check result beats first so a beat accepted on the same edge never
	// matches its own prediction
	always @(posedge clk or negedge arst_n) begin
		heap_result_t exp_r;
		heap_result_t got_r;
		if (!arst_n) begin
			heap_len       = 0;
			order_sel      = ORDER_MAX;
			mismatch_count = 0;
			expected_q.delete();
		end else begin
			if (m_tvalid && m_tready) begin
				got_r.top_value = m_tdata[DATA_W-1:0];
				got_r.is_empty  = m_tuser[0];
				got_r.count     = m_tdata[DATA_W+CNT_W-1:DATA_W];
				got_r.status    = status_t'(m_tuser[M_USER_W-1:1]);
				if (expected_q.size() == 0) begin
					$error("result beat with nothing pending: top_value %0d count %0d",
						$signed(got_r.top_value), got_r.count);
					mismatch_count++;
				end else begin
					exp_r = expected_q.pop_front();
					check_field("top_value", $signed(exp_r.top_value),
						$signed(got_r.top_value));
					check_field("is_empty", exp_r.is_empty, got_r.is_empty);
					check_field("count", exp_r.count, got_r.count);
					check_field("status", exp_r.status, got_r.status);
				end
			end
			if (s_tvalid && s_tready) begin
				predict_beat(s_tuser[0], s_tdata, exp_r);
				expected_q.push_back(exp_r);
			end
			if (cfg_we)
				order_sel = cfg_wdata[0];
		end
		pending = expected_q.size();
		stored  = heap_len;
	end

endmodule

### dv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Heap queue testbench top
// Drives push and pop beats into the heap queue with random gaps and result
// backpressure, switches the heap order between phases, and gives the verdict
// from the checker's mismatch count.
// ----------------------------------------------------------------------------
module tb_top
	import bhpq_pkg::*;
();

	localparam int QUIET_LIMIT  = 4000;
	localparam int DRAIN_CYCLES = 60;

	logic                clk;
	logic                arst_n;
	logic                cfg_we;
	logic [0:0]          cfg_wdata;
	logic                s_tvalid;
	logic                s_tready;
	logic [31:0]         s_tdata;
	logic [0:0]          s_tuser;
	logic                m_tvalid;
	logic                m_tready;
	logic [M_DATA_W-1:0] m_tdata;
	logic [M_USER_W-1:0] m_tuser;

	int mismatch_count;
	int pending;
	int stored;
	int tx_idle_pct;
	int rx_stall_pct;
	int quiet_cycles;

	binary_heap_priority_queue u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	heap_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.s_tvalid       (s_tvalid),
		.s_tready       (s_tready),
		.s_tdata        (s_tdata),
		.s_tuser        (s_tuser),
		.m_tvalid       (m_tvalid),
		.m_tready       (m_tready),
		.m_tdata        (m_tdata),
		.m_tuser        (m_tuser),
		.mismatch_count (mismatch_count),
		.pending        (pending),
		.stored         (stored)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// Stall the result channel at random
	always @(negedge clk) begin
		m_tready = ($urandom_range(0, 99) >= rx_stall_pct);
	end

	// End the run when no beat moves on either channel for too long
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("tb_top NOT OK");
			$finish;
		end
	end

	// Mix of ties, extremes and full-range values
	function automatic logic [31:0] heap_value();
		case ($urandom_range(0, 9))
			0, 1: return $urandom_range(0, 7) - 32'd4;
			2: begin
				case ($urandom_range(0, 3))
					0: return 32'h7FFF_FFFF;
					1: return 32'h8000_0000;
					2: return 32'h0000_0000;
					default: return 32'hFFFF_FFFF;
				endcase
			end
			default: return $urandom;
		endcase
	endfunction

	// Present one beat, with random idle cycles ahead of it, and hold it
	// until accepted
	task automatic send_item(input logic fn, input logic [31:0] v);
		@(negedge clk);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser  = fn;
		s_tdata  = v;
		do @(posedge clk); while (!s_tready);
	endtask

	task automatic send_random(int n, int push_pct);
		repeat (n)
			send_item(($urandom_range(0, 99) < push_pct) ? FUNC_PUSH : FUNC_POP,
				heap_value());
	endtask

	// Hold the input until every pending result has come back
	task automatic wait_drained();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic set_order(logic order);
		wait_drained();
		cfg_we    = 1'b1;
		cfg_wdata = order;
		@(negedge clk);
		cfg_we    = 1'b0;
	endtask

	initial begin
		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_wdata    = '0;
		s_tvalid     = 1'b0;
		s_tdata      = '0;
		s_tuser      = '0;
		tx_idle_pct  = 28;
		rx_stall_pct = 70;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		// Directed: empty pop, extremes, ties, drain to empty and past it
		set_order(ORDER_MAX);
		send_item(FUNC_POP, 32'h0);
		send_item(FUNC_PUSH, 32'h7FFF_FFFF);
		send_item(FUNC_PUSH, 32'h8000_0000);
		send_item(FUNC_PUSH, 32'h0000_0000);
		send_item(FUNC_PUSH, 32'hFFFF_FFFF);
		send_item(FUNC_PUSH, 32'hFFFF_FFFF);
		send_item(FUNC_PUSH, 32'd5);
		send_item(FUNC_PUSH, 32'd5);
		repeat (8) send_item(FUNC_POP, 32'hFFFF_FFFF);

		// Directed: min order with ties and extremes
		set_order(ORDER_MIN);
		send_item(FUNC_PUSH, 32'd3);
		send_item(FUNC_PUSH, 32'd3);
		send_item(FUNC_PUSH, 32'h8000_0000);
		send_item(FUNC_PUSH, 32'h7FFF_FFFF);
		send_item(FUNC_POP, 32'h0);
		send_item(FUNC_POP, 32'h0);

		// Random, min order, growing heap
		send_random(250, 65);

		// Flip the order with elements stored
		tx_idle_pct  = 70;
		rx_stall_pct = 28;
		set_order(ORDER_MAX);
		send_random(250, 70);

		// Fill to capacity and push past it, then churn at the full mark
		tx_idle_pct  = 0;
		rx_stall_pct = 0;
		wait_drained();
		repeat (CAPACITY - stored + 8)
			send_item(FUNC_PUSH, heap_value());
		send_random(100, 50);

		// Flip again near full and shrink
		set_order(ORDER_MIN);
		send_random(150, 25);

		wait_drained();
		if (mismatch_count == 0)
			$display("tb_top OK");
		else
			$display("tb_top NOT OK");
		$finish;
	end

endmodule

### binary_heap_priority_queue.f
+incdir+src
src/bhpq_pkg.sv
src/bhpq_ram.sv
src/bhpq_cmp.sv
src/binary_heap_priority_queue.sv
dv/heap_checker.sv
dv/tb_top.sv
